// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define WFS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication whose consequent must hold in the cycle after the trigger.
`define WFS_ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wfs_pkg.sv -----
// ----------------------------------------------------------------------------
// wfs_pkg
// Types and constants shared by the wall-following steering modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wfs_pkg;

  localparam int unsigned DistW  = 16;
  localparam int unsigned SpeedW = 7;
  localparam int unsigned TurnW  = 8;
  localparam int unsigned TiltW  = 10;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Follow modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  // Stuck escape window
  localparam logic [CountW-1:0] ESC_START = 5'd6;
  localparam logic [CountW-1:0] ESC_END   = 5'd20;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FOLLOW_MODE     = 3'd0,
    CFG_FORWARD_SPEED   = 3'd1,
    CFG_TURN_SPEED      = 3'd2,
    CFG_FRONT_LIMIT     = 3'd3,
    CFG_SIDE_FAR_LIMIT  = 3'd4,
    CFG_SIDE_NEAR_LIMIT = 3'd5,
    CFG_TILT_MARGIN     = 3'd6
  } cfg_idx_e;

  // Recorded turn direction of the rule
  typedef enum logic [1:0] {
    DIR_NONE     = 2'd0,
    DIR_LEFT     = 2'd1,
    DIR_RIGHT    = 2'd2,
    DIR_STRAIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic [1:0]        follow_mode;
    logic [SpeedW-1:0] forward_speed;
    logic [SpeedW-1:0] turn_speed;
    logic [DistW-1:0]  front_limit;
    logic [DistW-1:0]  side_far_limit;
    logic [DistW-1:0]  side_near_limit;
    logic [TiltW-1:0]  tilt_margin;
  } cfg_t;

  typedef struct packed {
    logic [DistW-1:0] right_rear_mm;
    logic [DistW-1:0] right_front_mm;
    logic [DistW-1:0] left_rear_mm;
    logic [DistW-1:0] left_front_mm;
    logic [DistW-1:0] front_mm;
  } sense_t;

  // Rule decision: drive straight, or turn toward / away from the wall
  typedef struct packed {
    logic go_fwd;
    logic turn_toward;
  } rule_t;

  typedef struct packed {
    logic              escaping;
    logic signed [TurnW-1:0] turn_cmd;
    logic [SpeedW-1:0] forward_cmd;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/wfs_rule.sv -----
// ----------------------------------------------------------------------------
// wfs_rule
// Hand-rule decision: wall ahead first, then three side distance bands.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_rule (
  input  wfs_pkg::cfg_t   cfg_i,
  input  wfs_pkg::sense_t sense_i,
  output wfs_pkg::rule_t  rule_o
);
  import wfs_pkg::*;

  logic [DistW-1:0] near_f, near_r, away_f;
  logic [DistW:0]   tilt_sum;
  logic             follow_left;

  assign follow_left = (cfg_i.follow_mode == MODE_LEFT);

  always_comb begin
    near_f = follow_left ? sense_i.left_front_mm  : sense_i.right_front_mm;
    near_r = follow_left ? sense_i.left_rear_mm   : sense_i.right_rear_mm;
    away_f = follow_left ? sense_i.right_front_mm : sense_i.left_front_mm;
  end

  // front - rear < -margin  <=>  front + margin < rear
  assign tilt_sum = {1'b0, near_f} + {{(DistW + 1 - TiltW){1'b0}}, cfg_i.tilt_margin};

  always_comb begin
    rule_o.go_fwd      = 1'b0;
    rule_o.turn_toward = 1'b0;
    if (sense_i.front_mm < cfg_i.front_limit) begin
      rule_o.turn_toward = (near_f > cfg_i.side_far_limit) &&
                           (away_f < cfg_i.side_far_limit);
    end else if (near_f <= cfg_i.side_near_limit || near_r <= cfg_i.side_near_limit) begin
      if (tilt_sum < {1'b0, near_r}) begin
        rule_o.turn_toward = 1'b0;
      end else begin
        rule_o.go_fwd = 1'b1;
      end
    end else if (near_f <= cfg_i.side_far_limit || near_r <= cfg_i.side_far_limit) begin
      if (near_f > near_r) begin
        rule_o.turn_toward = 1'b1;
      end else begin
        rule_o.go_fwd = 1'b1;
      end
    end else begin
      rule_o.turn_toward = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wfs_escape.sv -----
// ----------------------------------------------------------------------------
// wfs_escape
// Stuck counter, last turn direction and command generation with override.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_escape (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  wfs_pkg::cfg_t  cfg_i,
  input  wfs_pkg::rule_t rule_i,
  output wfs_pkg::res_t  res_o
);
  import wfs_pkg::*;

  logic [CountW-1:0] stuck_q, stuck_d, stuck_mid;
  dir_e              last_dir_q, last_dir_d;
  logic              active, toward_left, rule_left, turn_zero, clear, esc, out_left;
  logic [TurnW-1:0]  mag;

  assign active      = (cfg_i.follow_mode == MODE_LEFT) || (cfg_i.follow_mode == MODE_RIGHT);
  assign toward_left = (cfg_i.follow_mode == MODE_LEFT);
  assign rule_left   = toward_left ? rule_i.turn_toward : !rule_i.turn_toward;
  assign turn_zero   = rule_i.go_fwd || (cfg_i.turn_speed == '0);

  always_comb begin
    if (turn_zero) begin
      last_dir_d = DIR_STRAIGHT;
    end else if (rule_left) begin
      last_dir_d = DIR_LEFT;
    end else begin
      last_dir_d = DIR_RIGHT;
    end
  end

  // Driving forward, a zero forward speed or going straight resets the count
  assign clear = rule_i.go_fwd || (cfg_i.forward_speed == '0) || (last_dir_d == DIR_STRAIGHT);

  always_comb begin
    if (clear) begin
      stuck_mid = '0;
    end else if (last_dir_q != last_dir_d) begin
      stuck_mid = stuck_q + 1'b1;
    end else begin
      stuck_mid = stuck_q;
    end
    esc = (stuck_mid >= ESC_START) && (stuck_mid <= ESC_END);
    if (esc) begin
      stuck_d = stuck_mid + 1'b1;
    end else if (stuck_mid > ESC_END) begin
      stuck_d = '0;
    end else begin
      stuck_d = stuck_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_q    <= '0;
      last_dir_q <= DIR_NONE;
    end else if (step_i && active) begin
      stuck_q    <= stuck_d;
      last_dir_q <= last_dir_d;
    end
  end

  // Escape turns away from the followed wall
  assign out_left = esc ? !toward_left : rule_left;
  assign mag = (esc || !rule_i.go_fwd) ? {1'b0, cfg_i.turn_speed} : '0;

  always_comb begin
    res_o = '0;
    if (active) begin
      res_o.escaping    = esc;
      res_o.forward_cmd = (!esc && rule_i.go_fwd) ? cfg_i.forward_speed : '0;
      res_o.turn_cmd    = out_left ? $signed(mag) : -$signed(mag);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wall_follow_steering.sv -----
// Path: a taken input frame waits in the input register and then moves into the
// result register, whose contents the master side presents as valid.
// Throughput: one frame per cycle unless stalled; the input and result registers
// advance together whenever the result register is empty or being taken.
// Reset: clears both valid flags and the stuck count, sets the last turn
// direction to none and loads every configuration register with its default.
// ----------------------------------------------------------------------------
// wall_follow_steering
// Wall-following steering controller on a registered single-pass datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follow_steering (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // front_mm, left_front_mm, left_rear_mm, right_front_mm, right_rear_mm
  input  logic [79:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // forward_cmd [6:0], turn_cmd [14:7], zero [15]
  output logic [15:0]                   m_axis_tdata,
  // escaping
  output logic [0:0]                    m_axis_tuser
);
  import wfs_pkg::*;

  cfg_t   cfg_q;
  sense_t in_q;
  logic   in_valid_q, out_valid_q, advance;
  rule_t  rule;
  res_t   res, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.follow_mode     <= MODE_OFF;
      cfg_q.forward_speed   <= 7'd40;
      cfg_q.turn_speed      <= 7'd36;
      cfg_q.front_limit     <= 16'd450;
      cfg_q.side_far_limit  <= 16'd520;
      cfg_q.side_near_limit <= 16'd300;
      cfg_q.tilt_margin     <= 10'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FOLLOW_MODE:     cfg_q.follow_mode     <= cfg_wdata_i[1:0];
        CFG_FORWARD_SPEED:   cfg_q.forward_speed   <= cfg_wdata_i[SpeedW-1:0];
        CFG_TURN_SPEED:      cfg_q.turn_speed      <= cfg_wdata_i[SpeedW-1:0];
        CFG_FRONT_LIMIT:     cfg_q.front_limit     <= cfg_wdata_i[DistW-1:0];
        CFG_SIDE_FAR_LIMIT:  cfg_q.side_far_limit  <= cfg_wdata_i[DistW-1:0];
        CFG_SIDE_NEAR_LIMIT: cfg_q.side_near_limit <= cfg_wdata_i[DistW-1:0];
        CFG_TILT_MARGIN:     cfg_q.tilt_margin     <= cfg_wdata_i[TiltW-1:0];
        default: ;
      endcase
    end
  end

  // Move the held frame into the result register when that register is free or being taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  wfs_rule u_rule (
    .cfg_i   (cfg_q),
    .sense_i (in_q),
    .rule_o  (rule)
  );

  wfs_escape u_escape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg_q),
    .rule_i (rule),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.turn_cmd, res_q.forward_cmd};
  assign m_axis_tuser  = res_q.escaping;

endmodule

`default_nettype wire

// ----- rtl/wfs_checker.sv -----
// ----------------------------------------------------------------------------
// wfs_checker
// Port-level checks of the steering result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic stall;
  logic fwd_nz;
  logic turn_nz;

  assign stall   = m_axis_tvalid && !m_axis_tready;
  assign fwd_nz  = (m_axis_tdata[6:0] != 7'd0);
  assign turn_nz = (m_axis_tdata[14:7] != 8'd0);

  `WFS_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, stall, m_axis_tvalid, "result dropped while stalled")
  `WFS_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, stall, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `WFS_ASSERT(a_fwd_no_turn, clk_i, rst_ni, !(m_axis_tvalid && fwd_nz) || !turn_nz, "forward and turn both set")
  `WFS_ASSERT(a_esc_stops, clk_i, rst_ni, !(m_axis_tvalid && m_axis_tuser[0]) || !fwd_nz, "escape with forward motion")

endmodule

bind wall_follow_steering wfs_checker u_wfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
